/* src/dmpc_pkg.sv */
package dmpc_pkg;

    // Converter reading width and mid-scale reference
    localparam int unsigned SAMPLE_BITS = 10;
    localparam logic [SAMPLE_BITS-1:0] MID_SCALE = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);

    // Register field widths and reset values
    localparam int unsigned LEVEL_BITS = 5;
    localparam int unsigned RUN_BITS   = 3;
    localparam int unsigned TOTAL_BITS = 16;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 5'd8;
    localparam logic [RUN_BITS-1:0]   RUN_RESET   = 3'd3;

    // APB address map
    localparam int unsigned ADDR_BITS = 3;
    localparam logic REG_DETECT_LEVEL = 1'b0;
    localparam logic REG_RUN_LENGTH   = 1'b1;

    // Request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic                   opcode;
        logic [SAMPLE_BITS-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                  pass_pulse;
        logic [TOTAL_BITS-1:0] pass_total;
        logic                  detector_active;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] detect_level;
        logic [RUN_BITS-1:0]   run_length;
    } cfg_t;

endpackage

/* src/dmpc_cfg.sv */
module dmpc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmpc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output dmpc_pkg::cfg_t                  cfg
);
    import dmpc_pkg::*;

    logic [LEVEL_BITS-1:0] level_reg;
    logic [RUN_BITS-1:0]   run_reg;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the selected register on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= LEVEL_RESET;
            run_reg   <= RUN_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_DETECT_LEVEL: level_reg <= pwdata[LEVEL_BITS-1:0];
                REG_RUN_LENGTH:   run_reg   <= pwdata[RUN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Return the selected register on reads
    always_comb begin
        unique case (paddr[2])
            REG_DETECT_LEVEL: prdata = {{(32-LEVEL_BITS){1'b0}}, level_reg};
            REG_RUN_LENGTH:   prdata = {{(32-RUN_BITS){1'b0}}, run_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.detect_level = level_reg;
    assign cfg.run_length   = run_reg;

endmodule

/* src/dmpc_core.sv */
module dmpc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  dmpc_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  dmpc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dmpc_pkg::out_item_t m_data
);
    import dmpc_pkg::*;

    logic                   active_reg, active_next;
    logic [RUN_BITS-1:0]    run_count_reg, run_count_next;
    logic [TOTAL_BITS-1:0]  passes_reg, passes_next;
    logic                   m_valid_reg;
    out_item_t              m_data_reg, m_data_next;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] sample_dist;
    logic                   present;
    logic                   qualifies;
    logic [RUN_BITS:0]      run_inc;
    logic [RUN_BITS:0]      run_cand;
    logic                   run_done;

    // Take a new request whenever the result slot is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Distance from mid-scale and run qualification
    always_comb begin
        sample_dist = (s_data.sample >= MID_SCALE) ? (s_data.sample - MID_SCALE)
                                                   : (MID_SCALE - s_data.sample);
        present     = sample_dist >= SAMPLE_BITS'(cfg.detect_level);
        qualifies   = active_reg ? !present : present;
        run_inc     = {1'b0, run_count_reg} + (RUN_BITS+1)'(1);
        run_cand    = qualifies ? run_inc : '0;
        run_done    = run_cand >= {1'b0, cfg.run_length};
    end

    // Next detector state, pass total and result
    always_comb begin
        active_next    = active_reg;
        run_count_next = run_count_reg;
        passes_next    = passes_reg;
        m_data_next    = '0;
        if (s_data.opcode == OP_READ) begin
            m_data_next.pass_total = passes_reg;
            passes_next            = '0;
        end else begin
            run_count_next = run_cand[RUN_BITS-1:0];
            if (run_done) begin
                run_count_next = '0;
                active_next    = !active_reg;
                if (active_reg) begin
                    passes_next            = passes_reg + TOTAL_BITS'(1);
                    m_data_next.pass_pulse = 1'b1;
                end
            end
        end
        m_data_next.detector_active = active_next;
    end

    // Advance state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            run_count_reg <= '0;
            passes_reg    <= '0;
        end else if (accept) begin
            active_reg    <= active_next;
            run_count_reg <= run_count_next;
            passes_reg    <= passes_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/debounced_magnet_pass_counter.sv */
// Result: an accepted request's result is registered and shown on the m_ channel in the cycle after its handshake.
// Throughput: one request per cycle while the m_ channel is not stalled; the detector
// update is combinational between the request handshake and the result register.
// Reset: synchronous active-low aresetn sets detector idle, run count and pass
// total to zero, detect_level to 8 and run_length to 3.
module debounced_magnet_pass_counter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dmpc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dmpc_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dmpc_pkg::out_item_t             m_data
);
    import dmpc_pkg::*;

    cfg_t cfg;

    dmpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* test/tb_top.sv */
// Scoreboard: tracks detector state, run count and pass total, and queues
// the result that each request should produce.
class pass_scoreboard;
    logic [dmpc_pkg::LEVEL_BITS-1:0] level;
    logic [dmpc_pkg::RUN_BITS-1:0]   run_len;
    logic                            active;
    logic [dmpc_pkg::RUN_BITS-1:0]   run_cnt;
    logic [dmpc_pkg::TOTAL_BITS-1:0] passes;
    dmpc_pkg::out_item_t             pending_q[$];
    int                              errors;
    int                              checked;
    int                              pulses;
    int                              reads;

    function new();
        level   = dmpc_pkg::LEVEL_RESET;
        run_len = dmpc_pkg::RUN_RESET;
        active  = 1'b0;
        run_cnt = '0;
        passes  = '0;
        errors  = 0;
        checked = 0;
        pulses  = 0;
        reads   = 0;
    endfunction

    function void set_level(logic [dmpc_pkg::LEVEL_BITS-1:0] v);
        level = v;
    endfunction

    function void set_run(logic [dmpc_pkg::RUN_BITS-1:0] v);
        run_len = v;
    endfunction

    // Advance the detector for one accepted request and queue its result
    function void note_request(dmpc_pkg::in_item_t req);
        dmpc_pkg::out_item_t res;
        int                  sample_dist;
        int                  next_run;
        logic                present;
        logic                qual;
        res = '0;
        if (req.opcode == dmpc_pkg::OP_READ) begin
            res.pass_total = passes;
            passes = '0;
            reads++;
        end else begin
            if (req.sample >= dmpc_pkg::MID_SCALE)
                sample_dist = int'(req.sample) - int'(dmpc_pkg::MID_SCALE);
            else
                sample_dist = int'(dmpc_pkg::MID_SCALE) - int'(req.sample);
            present  = (sample_dist >= int'(level));
            qual     = active ? !present : present;
            next_run = qual ? int'(run_cnt) + 1 : 0;
            if (next_run >= int'(run_len)) begin
                next_run = 0;
                if (active) begin
                    passes = passes + dmpc_pkg::TOTAL_BITS'(1);
                    res.pass_pulse = 1'b1;
                    pulses++;
                end
                active = !active;
            end
            run_cnt = next_run[dmpc_pkg::RUN_BITS-1:0];
        end
        res.detector_active = active;
        pending_q.push_back(res);
    endfunction

    task report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Compare a result with the oldest queued one
    task check_result(dmpc_pkg::out_item_t res);
        dmpc_pkg::out_item_t want;
        if (pending_q.size() == 0) begin
            report("result with nothing pending", int'(res), 0);
        end else begin
            want = pending_q.pop_front();
            checked++;
            if (res.pass_pulse !== want.pass_pulse)
                report("pass_pulse", res.pass_pulse, want.pass_pulse);
            if (res.pass_total !== want.pass_total)
                report("pass_total", res.pass_total, want.pass_total);
            if (res.detector_active !== want.detector_active)
                report("detector_active", res.detector_active, want.detector_active);
        end
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmpc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 128;
    localparam int IDLE_PERCENT = 35;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;

    logic                 calm;
    int                   cycles = 0;
    int                   sent;
    pass_scoreboard       sb;

    debounced_magnet_pass_counter uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     sb.pending_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result channel at random unless in a calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Note accepted requests, then check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    // Offer one request, with a random gap first, and hold it until taken
    task send_request(logic op, logic [SAMPLE_BITS-1:0] smp);
        in_item_t req;
        int       gap;
        req.opcode = op;
        req.sample = smp;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        sent++;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Drop valid and wait until every result is back, plus the block latency
    task drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write a register, then read it back
    task write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] value, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want)
            sb.report("register readback", int'(prdata), int'(want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task set_config(logic [LEVEL_BITS-1:0] lvl, logic [RUN_BITS-1:0] run);
        logic [31:0] junk;
        junk = $urandom_range(0, 1) ? $urandom() : 32'h0;
        write_reg({REG_DETECT_LEVEL, 2'b00}, (junk & ~32'h1F) | 32'(lvl), 32'(lvl));
        sb.set_level(lvl);
        junk = $urandom_range(0, 1) ? $urandom() : 32'h0;
        write_reg({REG_RUN_LENGTH, 2'b00}, (junk & ~32'h7) | 32'(run), 32'(run));
        sb.set_run(run);
        @(posedge aclk);
    endtask

    // Place a reading at a given distance from mid-scale, either side
    function logic [SAMPLE_BITS-1:0] at_distance(int d);
        if (d > 511 || (d > 0 && $urandom_range(0, 1)))
            return SAMPLE_BITS'(int'(MID_SCALE) + d);
        return SAMPLE_BITS'(int'(MID_SCALE) - d);
    endfunction

    function logic [SAMPLE_BITS-1:0] magnet_sample();
        int lvl;
        lvl = int'(sb.level);
        if ($urandom_range(0, 1))
            return at_distance($urandom_range(lvl, lvl + 2));
        return at_distance($urandom_range(lvl, 512));
    endfunction

    function logic [SAMPLE_BITS-1:0] quiet_sample();
        int lvl;
        lvl = int'(sb.level);
        if (lvl == 0)
            return magnet_sample();
        if ($urandom_range(0, 1))
            return at_distance(lvl - 1);
        return at_distance($urandom_range(0, lvl - 1));
    endfunction

    // Bursts of magnet and quiet samples, some cut short, plus reads and noise
    task random_phase(int count);
        int   n;
        int   burst;
        int   r;
        logic want_magnet;
        n = 0;
        want_magnet = !sb.active;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                send_request(OP_READ, SAMPLE_BITS'($urandom()));
                n++;
            end else if (r < 15) begin
                send_request(OP_SAMPLE, SAMPLE_BITS'($urandom()));
                n++;
            end else begin
                burst = $urandom_range(0, int'(sb.run_len) + 2);
                for (int i = 0; i < burst && n < count; i++) begin
                    send_request(OP_SAMPLE, want_magnet ? magnet_sample() : quiet_sample());
                    n++;
                end
                want_magnet = !want_magnet;
            end
        end
    endtask

    initial begin
        logic [LEVEL_BITS-1:0] lvl_set [PHASES];
        logic [RUN_BITS-1:0]   run_set [PHASES];

        sb = new();
        sent = 0;
        lvl_set = '{5'd8, 5'd0, 5'd31, 5'd0, 5'd31, 5'd8, 5'd1, 5'd0, 5'd0, 5'd0};
        run_set = '{3'd3, 3'd0, 3'd7, 3'd7, 3'd0, 3'd1, 3'd7, 3'd0, 3'd0, 3'd0};
        for (int p = 7; p < PHASES; p++) begin
            lvl_set[p] = LEVEL_BITS'($urandom_range(0, 31));
            run_set[p] = RUN_BITS'($urandom_range(0, 7));
        end

        // Hold every input at a known value through reset
        calm    <= 1'b0;
        aresetn <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: threshold edges and field extremes at the reset settings
        send_request(OP_READ, '0);
        send_request(OP_SAMPLE, 10'd511);
        send_request(OP_SAMPLE, 10'd519);
        send_request(OP_SAMPLE, 10'd503);
        send_request(OP_SAMPLE, 10'd504);
        send_request(OP_SAMPLE, 10'd1023);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'd518);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_READ, 10'h3FF);
        send_request(OP_SAMPLE, 10'd1023);
        send_request(OP_SAMPLE, 10'd512);
        send_request(OP_SAMPLE, 10'd510);
        send_request(OP_SAMPLE, 10'd504);
        send_request(OP_SAMPLE, 10'd518);
        send_request(OP_READ, 10'h155);
        send_request(OP_READ, 10'h2AA);
        // Leave part of a run behind to see a lowered run_length finish it
        send_request(OP_SAMPLE, 10'd700);
        send_request(OP_SAMPLE, 10'd300);
        drain();

        // Zero level and zero run: every sample flips the detector
        set_config(5'd0, 3'd0);
        send_request(OP_SAMPLE, 10'd511);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'd1023);
        send_request(OP_SAMPLE, 10'd511);
        send_request(OP_READ, '0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                set_config(lvl_set[p], run_set[p]);
            end
            calm <= (p == 3);
            random_phase(PHASE_ITEMS);
            drain();
        end
        calm <= 1'b0;
        send_request(OP_READ, '0);
        drain();

        $display("covered %0d requests over %0d settings: %0d results, %0d passes, %0d reads",
                 sent, PHASES + 1, sb.checked, sb.pulses, sb.reads);
        $display("%0d mismatches, %0d cycles", sb.errors, cycles);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
